// ----- sv/occ_pkg.sv -----
`default_nettype none

package occ_pkg;

  // Input operation codes.
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_STOP = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  // Opcodes of the command set.
  localparam logic [7:0] CMD_ADDR_MODE   = 8'h20;
  localparam logic [7:0] CMD_COL_WINDOW  = 8'h21;
  localparam logic [7:0] CMD_PAGE_WINDOW = 8'h22;
  localparam logic [7:0] CMD_SCROLL_R    = 8'h26;
  localparam logic [7:0] CMD_SCROLL_L    = 8'h27;
  localparam logic [7:0] CMD_SCROLL_VR   = 8'h29;
  localparam logic [7:0] CMD_SCROLL_VL   = 8'h2A;
  localparam logic [7:0] CMD_SCROLL_OFF  = 8'h2E;
  localparam logic [7:0] CMD_SCROLL_ON   = 8'h2F;
  localparam logic [7:0] CMD_CONTRAST    = 8'h81;
  localparam logic [7:0] CMD_CHARGE_PUMP = 8'h8D;
  localparam logic [7:0] CMD_VSCROLL_AREA = 8'hA3;
  localparam logic [7:0] CMD_RESUME_RAM  = 8'hA4;
  localparam logic [7:0] CMD_FULL_ON     = 8'hA5;
  localparam logic [7:0] CMD_NORMAL      = 8'hA6;
  localparam logic [7:0] CMD_INVERT      = 8'hA7;
  localparam logic [7:0] CMD_MUX_RATIO   = 8'hA8;
  localparam logic [7:0] CMD_DISPLAY_OFF = 8'hAE;
  localparam logic [7:0] CMD_DISPLAY_ON  = 8'hAF;
  localparam logic [7:0] CMD_PAGE_BASE   = 8'hB0;
  localparam logic [7:0] CMD_PAGE_TOP    = 8'hB7;
  localparam logic [7:0] CMD_OFFSET      = 8'hD3;
  localparam logic [7:0] CMD_CLOCK_DIV   = 8'hD5;
  localparam logic [7:0] CMD_PRECHARGE   = 8'hD9;
  localparam logic [7:0] CMD_COM_PINS    = 8'hDA;
  localparam logic [7:0] CMD_VCOMH       = 8'hDB;

  localparam logic [1:0] MODE_HORIZONTAL = 2'd0;
  localparam logic [1:0] MODE_VERTICAL   = 2'd1;

  // Scroll interval in frames, indexed by the interval argument.
  localparam logic [8:0] IntervalTable [8] = '{9'd5, 9'd64, 9'd128, 9'd256,
                                               9'd3, 9'd4, 9'd25, 9'd2};
  // The same interval divided by five, loaded when scrolling starts.
  localparam logic [8:0] StartTable [8] = '{9'd1, 9'd12, 9'd25, 9'd51,
                                            9'd0, 9'd0, 9'd5, 9'd0};

  typedef struct packed {
    logic accept;
    logic clear_step;
    logic exec;
    logic rot_pre;
    logic rot_hold;
    logic rot_rd;
    logic rot_wr;
    logic rot_last;
    logic load;
  } occ_cmd_t;

  typedef struct packed {
    logic       clear_done;
    logic [1:0] op;
    logic       tick_fire;
    logic       rot_page_ok;
    logic       rot_k_last;
  } occ_sts_t;

endpackage

`default_nettype wire

// ----- sv/occ_ctrl.sv -----
`default_nettype none

module occ_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire occ_pkg::occ_sts_t sts_i,
  output occ_pkg::occ_cmd_t     cmd_o
);
  import occ_pkg::*;

  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_EXEC     = 4'd2;
  localparam logic [3:0] ST_ROT_PAGE = 4'd3;
  localparam logic [3:0] ST_ROT_PRE  = 4'd4;
  localparam logic [3:0] ST_ROT_HOLD = 4'd5;
  localparam logic [3:0] ST_ROT_RD   = 4'd6;
  localparam logic [3:0] ST_ROT_WR   = 4'd7;
  localparam logic [3:0] ST_ROT_LAST = 4'd8;
  localparam logic [3:0] ST_LOAD     = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.op == OP_TICK && sts_i.tick_fire) state_d = ST_ROT_PAGE;
        else state_d = ST_LOAD;
      end
      ST_ROT_PAGE: begin
        state_d = sts_i.rot_page_ok ? ST_ROT_PRE : ST_LOAD;
      end
      ST_ROT_PRE: begin
        cmd_o.rot_pre = 1'b1;
        state_d       = ST_ROT_HOLD;
      end
      ST_ROT_HOLD: begin
        cmd_o.rot_hold = 1'b1;
        state_d        = ST_ROT_RD;
      end
      ST_ROT_RD: begin
        cmd_o.rot_rd = 1'b1;
        state_d      = ST_ROT_WR;
      end
      ST_ROT_WR: begin
        cmd_o.rot_wr = 1'b1;
        state_d      = sts_i.rot_k_last ? ST_ROT_LAST : ST_ROT_RD;
      end
      ST_ROT_LAST: begin
        cmd_o.rot_last = 1'b1;
        state_d        = ST_ROT_PAGE;
      end
      ST_LOAD: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- sv/occ_dp.sv -----
`default_nettype none

module occ_dp #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire occ_pkg::occ_cmd_t cmd_i,
  output occ_pkg::occ_sts_t      sts_o,
  input  wire logic [1:0]        operation_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic [6:0]        read_column_i,
  input  wire logic [2:0]        read_page_i,
  output logic [7:0]             pixel_column_o,
  output logic [6:0]             column_pointer_o,
  output logic [2:0]             page_pointer_o,
  output logic                   scroll_running_o,
  output logic                   display_enabled_o
);
  import occ_pkg::*;

  localparam int AW    = $clog2(COLUMNS * PAGES);
  localparam int KW    = $clog2(COLUMNS);
  localparam int DEPTH = COLUMNS * PAGES;
  localparam logic [7:0] ColLimit  = 8'(COLUMNS);
  localparam logic [3:0] PageLimit = 4'(PAGES);
  localparam logic [6:0] ColLast   = 7'(COLUMNS - 1);
  localparam logic [6:0] ColPrev   = 7'(COLUMNS - 2);

  function automatic logic [AW-1:0] addr_of(input logic [6:0] c, input logic [2:0] p);
    logic [10:0] full;
    full = 11'(p) * 11'(COLUMNS) + 11'(c);
    return full[AW-1:0];
  endfunction

  logic [7:0] mem [DEPTH];

  logic [1:0] op_q;
  logic [7:0] byte_q;
  logic [6:0] rcol_q;
  logic [2:0] rpage_q;

  logic [6:0] col_q, col_d, wfc_q, wfc_d, wlc_q, wlc_d;
  logic [2:0] page_q, page_d, wfp_q, wfp_d, wlp_q, wlp_d;
  logic [1:0] mode_q, mode_d;
  logic [2:0] args_q, args_d;
  logic [7:0] pend_q, pend_d;
  logic       sf_cmd_q, sf_cmd_d, sf_data_q, sf_data_d, sf_cont_q, sf_cont_d;
  logic       on_q, on_d, full_q, full_d, inv_q, inv_d;
  logic       act_q, act_d, right_q, right_d;
  logic [2:0] sfp_q, sfp_d, slp_q, slp_d, sint_q, sint_d;
  logic [8:0] cnt_q, cnt_d;
  logic [3:0] rpg_q, rpg_d;

  logic [AW-1:0] clr_q;
  logic [KW-1:0] k_q;
  logic [7:0]    hold_q, rdata_q;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata;

  logic [7:0] adv_col;
  logic [3:0] adv_page;
  logic [2:0] arg_pos;
  logic [2:0] arg_val;
  logic       scroll_op, data_fits, fire;
  logic [6:0] rot_dst, rot_src, rot_start, rot_end;

  assign fire      = on_q && act_q && (cnt_q <= 9'd1);
  assign data_fits = ({1'b0, col_q} < ColLimit) && ({1'b0, page_q} < PageLimit);
  assign scroll_op = (pend_q == CMD_SCROLL_R) || (pend_q == CMD_SCROLL_L) ||
                     (pend_q == CMD_SCROLL_VR) || (pend_q == CMD_SCROLL_VL);
  assign arg_pos   = ((pend_q == CMD_SCROLL_R) || (pend_q == CMD_SCROLL_L)) ?
                     3'd6 - args_q : 3'd5 - args_q;
  assign arg_val   = byte_q[2:0];

  // Pointer auto-increment inside the window.
  always_comb begin
    adv_col  = {1'b0, col_q};
    adv_page = {1'b0, page_q};
    if (mode_q == MODE_VERTICAL) begin
      adv_page = adv_page + 4'd1;
      if (adv_page > {1'b0, wlp_q}) begin
        adv_page = {1'b0, wfp_q};
        adv_col  = adv_col + 8'd1;
      end
      if (adv_col > {1'b0, wlc_q}) adv_col = {1'b0, wfc_q};
    end else begin
      adv_col = adv_col + 8'd1;
      if (adv_col > {1'b0, wlc_q}) begin
        adv_col = {1'b0, wfc_q};
        if (mode_q == MODE_HORIZONTAL) adv_page = adv_page + 4'd1;
      end
      if (mode_q == MODE_HORIZONTAL && adv_page > {1'b0, wlp_q}) adv_page = {1'b0, wfp_q};
    end
  end

  // Rotation addresses: a left scroll moves each byte one column down.
  always_comb begin
    if (right_q) begin
      rot_dst   = ColLast - 7'(k_q);
      rot_src   = ColPrev - 7'(k_q);
      rot_start = ColLast;
      rot_end   = 7'd0;
    end else begin
      rot_dst   = 7'(k_q);
      rot_src   = 7'(k_q) + 7'd1;
      rot_start = 7'd0;
      rot_end   = ColLast;
    end
  end

  always_comb begin
    col_d = col_q; page_d = page_q; wfc_d = wfc_q; wlc_d = wlc_q;
    wfp_d = wfp_q; wlp_d = wlp_q; mode_d = mode_q; args_d = args_q; pend_d = pend_q;
    sf_cmd_d = sf_cmd_q; sf_data_d = sf_data_q; sf_cont_d = sf_cont_q;
    on_d = on_q; full_d = full_q; inv_d = inv_q; act_d = act_q; right_d = right_q;
    sfp_d = sfp_q; slp_d = slp_q; sint_d = sint_q; cnt_d = cnt_q; rpg_d = rpg_q;
    we = 1'b0; waddr = '0; wdata = '0;

    if (cmd_i.exec) begin
      unique case (op_q)
        OP_BYTE: begin
          if (!sf_cmd_q && !sf_data_q) begin
            if (byte_q[5:0] == 6'd0) begin
              sf_cont_d = ~byte_q[7];
              sf_cmd_d  = (byte_q[6:0] == 7'd0);
              sf_data_d = (byte_q[6:0] != 7'd0);
            end
          end else begin
            if (sf_cmd_q) begin
              if (args_q != 3'd0) begin
                args_d = args_q - 3'd1;
                if (pend_q == CMD_ADDR_MODE) begin
                  mode_d = byte_q[1:0];
                end else if (pend_q == CMD_COL_WINDOW) begin
                  if (args_q == 3'd2) wfc_d = byte_q[6:0];
                  else wlc_d = byte_q[6:0];
                end else if (pend_q == CMD_PAGE_WINDOW) begin
                  if (args_q == 3'd2) wfp_d = byte_q[2:0];
                  else wlp_d = byte_q[2:0];
                end else if (scroll_op) begin
                  right_d = (pend_q == CMD_SCROLL_R) || (pend_q == CMD_SCROLL_VR);
                  if (arg_pos == 3'd1) sfp_d = arg_val;
                  else if (arg_pos == 3'd2) sint_d = arg_val;
                  else if (arg_pos == 3'd3) slp_d = arg_val;
                end
              end else begin
                pend_d = byte_q;
                priority if (byte_q < 8'h10) begin
                  col_d = {col_q[6:4], byte_q[3:0]};
                end else if (byte_q < 8'h20) begin
                  col_d = {byte_q[2:0], col_q[3:0]};
                end else if (byte_q == CMD_ADDR_MODE || byte_q == CMD_CONTRAST ||
                             byte_q == CMD_CHARGE_PUMP || byte_q == CMD_MUX_RATIO ||
                             byte_q == CMD_OFFSET || byte_q == CMD_CLOCK_DIV ||
                             byte_q == CMD_PRECHARGE || byte_q == CMD_COM_PINS ||
                             byte_q == CMD_VCOMH) begin
                  args_d = 3'd1;
                end else if (byte_q == CMD_COL_WINDOW || byte_q == CMD_PAGE_WINDOW ||
                             byte_q == CMD_VSCROLL_AREA) begin
                  args_d = 3'd2;
                end else if (byte_q == CMD_SCROLL_R || byte_q == CMD_SCROLL_L) begin
                  args_d = 3'd6;
                end else if (byte_q == CMD_SCROLL_VR || byte_q == CMD_SCROLL_VL) begin
                  args_d = 3'd5;
                end else if (byte_q == CMD_SCROLL_OFF) begin
                  act_d = 1'b0;
                end else if (byte_q == CMD_SCROLL_ON) begin
                  act_d = 1'b1;
                  cnt_d = StartTable[sint_q];
                end else if (byte_q == CMD_RESUME_RAM) begin
                  full_d = 1'b0;
                end else if (byte_q == CMD_FULL_ON) begin
                  full_d = 1'b1;
                end else if (byte_q == CMD_NORMAL) begin
                  inv_d = 1'b0;
                end else if (byte_q == CMD_INVERT) begin
                  inv_d = 1'b1;
                end else if (byte_q == CMD_DISPLAY_OFF) begin
                  col_d = '0; page_d = '0; wfc_d = '0; wlc_d = 7'd127;
                  wfp_d = '0; wlp_d = 3'd7; sfp_d = '0; slp_d = 3'd7; sint_d = '0;
                  args_d = '0; on_d = 1'b0; full_d = 1'b0; inv_d = 1'b0;
                  act_d = 1'b0; right_d = 1'b0;
                end else if (byte_q == CMD_DISPLAY_ON) begin
                  on_d = 1'b1;
                end else if (byte_q >= CMD_PAGE_BASE && byte_q <= CMD_PAGE_TOP) begin
                  page_d = byte_q[2:0];
                end else begin
                  args_d = args_q;
                end
              end
            end else begin
              we     = data_fits;
              waddr  = addr_of(col_q, page_q);
              wdata  = byte_q;
              col_d  = adv_col[6:0];
              page_d = adv_page[2:0];
            end
            if (!sf_cont_q) begin
              sf_cmd_d = 1'b0; sf_data_d = 1'b0; sf_cont_d = 1'b0;
            end
          end
        end
        OP_STOP: begin
          sf_cmd_d = 1'b0; sf_data_d = 1'b0; sf_cont_d = 1'b0;
        end
        OP_TICK: begin
          if (on_q && act_q) begin
            if (fire) begin
              cnt_d = IntervalTable[sint_q];
              rpg_d = {1'b0, sfp_q};
            end else begin
              cnt_d = cnt_q - 9'd1;
            end
          end
        end
        OP_READ: begin
        end
        default: begin
        end
      endcase
    end else if (cmd_i.clear_step) begin
      we    = 1'b1;
      waddr = clr_q;
    end else if (cmd_i.rot_wr) begin
      we    = 1'b1;
      waddr = addr_of(rot_dst, rpg_q[2:0]);
      wdata = rdata_q;
    end else if (cmd_i.rot_last) begin
      we    = 1'b1;
      waddr = addr_of(rot_end, rpg_q[2:0]);
      wdata = hold_q;
      rpg_d = rpg_q + 4'd1;
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = addr_of(rcol_q, rpage_q);
    if (cmd_i.exec && op_q == OP_READ) begin
      re = 1'b1;
    end else if (cmd_i.rot_pre) begin
      re    = 1'b1;
      raddr = addr_of(rot_start, rpg_q[2:0]);
    end else if (cmd_i.rot_rd) begin
      re    = 1'b1;
      raddr = addr_of(rot_src, rpg_q[2:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q    <= operation_i;
      byte_q  <= data_byte_i;
      rcol_q  <= read_column_i;
      rpage_q <= read_page_i;
    end
    if (cmd_i.rot_hold) hold_q <= rdata_q;
  end

  logic [7:0] pix;
  always_comb begin
    pix = 8'd0;
    if (op_q == OP_READ && on_q) begin
      if (full_q) pix = 8'hFF;
      else if (({1'b0, rcol_q} < ColLimit) && ({1'b0, rpage_q} < PageLimit)) pix = rdata_q;
      if (inv_q) pix = ~pix;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pixel_column_o    <= pix;
      column_pointer_o  <= col_q;
      page_pointer_o    <= page_q;
      scroll_running_o  <= act_q;
      display_enabled_o <= on_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0; page_q <= '0; wfc_q <= '0; wlc_q <= 7'd127;
      wfp_q <= '0; wlp_q <= 3'd7; mode_q <= MODE_HORIZONTAL; args_q <= '0; pend_q <= '0;
      sf_cmd_q <= 1'b0; sf_data_q <= 1'b0; sf_cont_q <= 1'b0;
      on_q <= 1'b0; full_q <= 1'b0; inv_q <= 1'b0; act_q <= 1'b0; right_q <= 1'b0;
      sfp_q <= '0; slp_q <= 3'd7; sint_q <= '0; cnt_q <= '0; rpg_q <= '0;
      clr_q <= '0; k_q <= '0;
    end else begin
      col_q <= col_d; page_q <= page_d; wfc_q <= wfc_d; wlc_q <= wlc_d;
      wfp_q <= wfp_d; wlp_q <= wlp_d; mode_q <= mode_d; args_q <= args_d; pend_q <= pend_d;
      sf_cmd_q <= sf_cmd_d; sf_data_q <= sf_data_d; sf_cont_q <= sf_cont_d;
      on_q <= on_d; full_q <= full_d; inv_q <= inv_d; act_q <= act_d; right_q <= right_d;
      sfp_q <= sfp_d; slp_q <= slp_d; sint_q <= sint_d; cnt_q <= cnt_d; rpg_q <= rpg_d;
      if (cmd_i.clear_step) clr_q <= clr_q + AW'(1);
      if (cmd_i.rot_hold) k_q <= '0;
      else if (cmd_i.rot_wr) k_q <= k_q + KW'(1);
    end
  end

  assign sts_o.clear_done  = (clr_q == AW'(DEPTH - 1));
  assign sts_o.op          = op_q;
  assign sts_o.tick_fire   = fire;
  assign sts_o.rot_page_ok = (rpg_q <= {1'b0, slp_q}) && (rpg_q < PageLimit);
  assign sts_o.rot_k_last  = (k_q == KW'(COLUMNS - 2));

endmodule

`default_nettype wire

// ----- sv/oled_controller_command_ram.sv -----
// A bus byte, stop or read passes through the execute and load states; the load state
// waits while an unaccepted result is still offered. A frame tick that scrolls rotates
// each page in turn, with one read and one write of the display memory per byte moved.
// One transaction is in work at a time; the next is taken once the result is registered.
// After reset a clearing pass writes zero to every address of the display memory,
// during which no input transaction is taken.
`default_nettype none

module oled_controller_command_ram #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // data_byte[7:0], read_column[14:8], read_page[17:15], zero fill
  input  wire logic [23:0] s_axis_tdata_i,
  // operation[1:0]
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // pixel_column[7:0], column_pointer[14:8], page_pointer[17:15],
  // scroll_running[18], display_enabled[19], zero fill
  output logic [23:0]      m_axis_tdata_o
);
  import occ_pkg::*;

  occ_cmd_t   cmd;
  occ_sts_t   sts;
  logic [7:0] pix;
  logic [6:0] col;
  logic [2:0] page;
  logic       scroll, enabled;

  occ_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  occ_dp #(.COLUMNS(COLUMNS), .PAGES(PAGES)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .operation_i       (s_axis_tuser_i),
    .data_byte_i       (s_axis_tdata_i[7:0]),
    .read_column_i     (s_axis_tdata_i[14:8]),
    .read_page_i       (s_axis_tdata_i[17:15]),
    .pixel_column_o    (pix),
    .column_pointer_o  (col),
    .page_pointer_o    (page),
    .scroll_running_o  (scroll),
    .display_enabled_o (enabled)
  );

  assign m_axis_tdata_o = {4'd0, enabled, scroll, page, col, pix};

endmodule

`default_nettype wire

// ----- sv/occ_checker.sv -----
`default_nettype none

module occ_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [23:0] s_axis_tdata_i,
  input wire logic [1:0]  s_axis_tuser_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [23:0] m_axis_tdata_o
);

  // A result that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result withdrawn before it was taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // Only one transaction is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while a transaction is in work");

  // With the display off every shown byte is blank.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[19] |-> m_axis_tdata_o[7:0] == 8'd0)
    else $error("pixel data shown while the display is off");

endmodule

bind oled_controller_command_ram occ_checker u_occ_checker (.*);

`default_nettype wire

// ----- dv/tb_top.sv -----
`default_nettype none

module tb_top;
  import occ_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class screen_scoreboard;
    logic [7:0] ram [1024];
    logic [6:0] col_ptr;
    logic [2:0] page_ptr;
    logic [6:0] win_c0, win_c1;
    logic [2:0] win_p0, win_p1;
    logic [1:0] mode;
    logic [2:0] args_left;
    logic [7:0] opcode;
    bit cmd_mode, data_mode, cont;
    bit disp_on, full_on, invert;
    bit scroll_on, scroll_right;
    logic [2:0] scr_p0, scr_p1;
    int unsigned interval, countdown;
    logic [19:0] pending [$];
    int errors;

    function void reset_settings();
      col_ptr = 0; page_ptr = 0; win_c0 = 0; win_c1 = 127; win_p0 = 0; win_p1 = 7;
      scr_p0 = 0; scr_p1 = 7; interval = 5; args_left = 0;
      disp_on = 0; full_on = 0; invert = 0; scroll_on = 0; scroll_right = 0;
    endfunction

    function new();
      foreach (ram[i]) ram[i] = 0;
      mode = MODE_HORIZONTAL; cmd_mode = 0; data_mode = 0; cont = 0;
      opcode = 0; countdown = 0; errors = 0;
      reset_settings();
    endfunction

    function void advance();
      int c, p;
      c = col_ptr; p = page_ptr;
      if (mode == MODE_VERTICAL) begin
        p++;
        if (p > win_p1) begin p = win_p0; c++; end
        if (c > win_c1) c = win_c0;
      end else begin
        c++;
        if (c > win_c1) begin
          c = win_c0;
          if (mode == MODE_HORIZONTAL) p++;
        end
        if (mode == MODE_HORIZONTAL && p > win_p1) p = win_p0;
      end
      col_ptr = c[6:0]; page_ptr = p[2:0];
    endfunction

    function void argument(logic [7:0] b);
      int total, pos;
      case (opcode)
        CMD_ADDR_MODE: mode = b[1:0];
        CMD_COL_WINDOW: if (args_left == 2) win_c0 = b[6:0]; else win_c1 = b[6:0];
        CMD_PAGE_WINDOW: if (args_left == 2) win_p0 = b[2:0]; else win_p1 = b[2:0];
        CMD_SCROLL_R, CMD_SCROLL_L, CMD_SCROLL_VR, CMD_SCROLL_VL: begin
          total = (opcode == CMD_SCROLL_R || opcode == CMD_SCROLL_L) ? 6 : 5;
          pos = total - args_left;
          scroll_right = (opcode == CMD_SCROLL_R || opcode == CMD_SCROLL_VR);
          if (pos == 1) scr_p0 = b[2:0];
          else if (pos == 2) interval = IntervalTable[b[2:0]];
          else if (pos == 3) scr_p1 = b[2:0];
        end
        default: ;
      endcase
      args_left--;
    endfunction

    function void command(logic [7:0] b);
      if (args_left > 0) begin
        argument(b);
        return;
      end
      opcode = b;
      if (b < 8'h10) col_ptr[3:0] = b[3:0];
      else if (b < 8'h20) col_ptr[6:4] = b[2:0];
      else case (b)
        CMD_ADDR_MODE, CMD_CONTRAST, CMD_CHARGE_PUMP, CMD_MUX_RATIO, CMD_OFFSET,
        CMD_CLOCK_DIV, CMD_PRECHARGE, CMD_COM_PINS, CMD_VCOMH: args_left = 1;
        CMD_COL_WINDOW, CMD_PAGE_WINDOW, CMD_VSCROLL_AREA: args_left = 2;
        CMD_SCROLL_R, CMD_SCROLL_L: args_left = 6;
        CMD_SCROLL_VR, CMD_SCROLL_VL: args_left = 5;
        CMD_SCROLL_OFF: scroll_on = 0;
        CMD_SCROLL_ON: begin scroll_on = 1; countdown = interval / 5; end
        CMD_RESUME_RAM: full_on = 0;
        CMD_FULL_ON: full_on = 1;
        CMD_NORMAL: invert = 0;
        CMD_INVERT: invert = 1;
        CMD_DISPLAY_OFF: reset_settings();
        CMD_DISPLAY_ON: disp_on = 1;
        default: if (b >= CMD_PAGE_BASE && b <= CMD_PAGE_TOP) page_ptr = b[2:0];
      endcase
    endfunction

    function void rotate();
      logic [7:0] keep;
      if (!disp_on || !scroll_on) return;
      if (countdown > 1) begin countdown--; return; end
      countdown = interval;
      for (int p = scr_p0; p <= scr_p1; p++) begin
        if (scroll_right) begin
          keep = ram[p*128+127];
          for (int c = 127; c > 0; c--) ram[p*128+c] = ram[p*128+c-1];
          ram[p*128] = keep;
        end else begin
          keep = ram[p*128];
          for (int c = 0; c < 127; c++) ram[p*128+c] = ram[p*128+c+1];
          ram[p*128+127] = keep;
        end
      end
    endfunction

    function void note_input(logic [1:0] op, logic [7:0] b, logic [6:0] rc, logic [2:0] rp);
      logic [7:0] pix;
      pix = 0;
      case (op)
        OP_BYTE: begin
          if (!cmd_mode && !data_mode) begin
            if (b[5:0] == 0) begin
              cont = !b[7]; cmd_mode = (b[6:0] == 0); data_mode = (b[6:0] != 0);
            end
          end else begin
            if (cmd_mode) command(b);
            else begin
              ram[{page_ptr, col_ptr}] = b;
              advance();
            end
            if (!cont) begin cmd_mode = 0; data_mode = 0; end
          end
        end
        OP_STOP: begin cmd_mode = 0; data_mode = 0; cont = 0; end
        OP_TICK: rotate();
        default: if (disp_on) begin
          pix = full_on ? 8'hFF : ram[{rp, rc}];
          if (invert) pix = ~pix;
        end
      endcase
      pending.push_back({disp_on, scroll_on, page_ptr, col_ptr, pix});
    endfunction

    function void check_result(logic [19:0] got);
      logic [19:0] want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch: expected pix %h col %0d page %0d scr %b on %b, got pix %h col %0d page %0d scr %b on %b",
                   want[7:0], want[14:8], want[17:15], want[18], want[19],
                   got[7:0], got[14:8], got[17:15], got[18], got[19]);
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid_i = 0, m_axis_tready_i = 0;
  logic [23:0] s_axis_tdata_i = 0;
  logic [1:0] s_axis_tuser_i = 0;
  logic s_axis_tready_o, m_axis_tvalid_o;
  logic [23:0] m_axis_tdata_o;
  screen_scoreboard board;
  bit sending_done = 0;

  oled_controller_command_ram dut (.*);

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  // The valid line is only lowered when a gap follows, so that a transaction sent
  // straight after the previous one takes a single update of the line.
  task automatic send_item(logic [1:0] op, logic [7:0] b, logic [6:0] rc = 0,
                           logic [2:0] rp = 0, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= {6'd0, rp, rc, b};
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_input(op, b, rc, rp);
  endtask

  task automatic send_command(logic [7:0] b);
    send_item(OP_BYTE, 8'h80, 0, 0);
    send_item(OP_BYTE, b, 0, 0);
  endtask

  task automatic read_any();
    send_item(OP_READ, 0, 7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)));
  endtask

  // Result side: random back-pressure, with calm stretches.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        m_axis_tready_i <= 0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      board.check_result(m_axis_tdata_o[19:0]);
    end
  end

  initial begin
    int kind, n, waited;
    logic [7:0] b;
    board = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;

    // Directed part.
    send_item(OP_BYTE, 8'h55, 0, 0);       // ignored while idle
    send_command(CMD_DISPLAY_ON);
    send_item(OP_BYTE, 8'h40, 0, 0);       // data, continuing
    send_item(OP_BYTE, 8'hFF, 0, 0);
    send_item(OP_BYTE, 8'h00, 0, 0);
    send_item(OP_BYTE, 8'hA5, 0, 0);
    send_item(OP_STOP, 0, 0, 0);
    send_item(OP_READ, 0, 7'd0, 3'd0);
    send_item(OP_READ, 0, 7'd127, 3'd7);
    send_item(OP_READ, 0, 7'd1, 3'd0);
    send_item(OP_BYTE, 8'h00, 0, 0);
    send_item(OP_BYTE, CMD_ADDR_MODE, 0, 0);
    send_item(OP_BYTE, 8'hFF, 0, 0);       // mode 3 acts as page
    send_item(OP_BYTE, 8'h1F, 0, 0);       // column high nibble, three bits
    send_item(OP_BYTE, CMD_FULL_ON, 0, 0);
    send_item(OP_READ, 0, 7'd5, 3'd2);
    send_item(OP_BYTE, CMD_INVERT, 0, 0);
    send_item(OP_READ, 0, 7'd5, 3'd2);
    send_item(OP_BYTE, CMD_DISPLAY_OFF, 0, 0);
    send_item(OP_TICK, 0, 0, 0);
    send_item(OP_STOP, 0, 0, 0);

    // Random part: mostly well-formed command and data sequences.
    n = 0;
    while (n < 270) begin
      kind = $urandom_range(0, 19);
      if (kind < 5) begin
        send_item(OP_BYTE, 8'h00, 0, 0);
        case ($urandom_range(0, 9))
          0: b = CMD_ADDR_MODE;
          1: b = CMD_COL_WINDOW;
          2: b = CMD_PAGE_WINDOW;
          3: b = 8'h26 + 8'($urandom_range(0, 1));
          4: b = 8'h29 + 8'($urandom_range(0, 1));
          5: b = $urandom_range(0, 1) ? CMD_SCROLL_ON : CMD_SCROLL_OFF;
          6: b = 8'hA4 + 8'($urandom_range(0, 3));
          7: b = $urandom_range(0, 7) ? CMD_DISPLAY_ON : CMD_DISPLAY_OFF;
          8: b = 8'($urandom_range(0, 8'h1F));
          default: b = $urandom_range(0, 3) ? 8'hB0 + 8'($urandom_range(0, 7))
                                           : 8'($urandom_range(0, 255));
        endcase
        send_item(OP_BYTE, b, 0, 0);
        repeat ($urandom_range(0, 6)) begin
          send_item(OP_BYTE, 8'($urandom_range(0, 255)), 0, 0);
          n++;
        end
        send_item(OP_STOP, 0, 0, 0);
        n += 3;
      end else if (kind < 9) begin
        send_item(OP_BYTE, $urandom_range(0, 1) ? 8'h40 : 8'hC0, 0, 0);
        repeat ($urandom_range(1, 8)) begin
          send_item(OP_BYTE, 8'($urandom_range(0, 255)), 0, 0, $urandom_range(0, 2) == 0);
          n++;
        end
        send_item(OP_STOP, 0, 0, 0);
        n += 2;
      end else if (kind < 11) begin
        send_item(OP_TICK, 0, 0, 0);
        n++;
      end else if (kind < 17) begin
        read_any();
        n++;
      end else begin
        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)));
        n++;
      end
    end
    s_axis_tvalid_i <= 0;

    waited = 0;
    while (board.pending.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (50) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ----- filelist.f -----
sv/occ_pkg.sv
sv/occ_ctrl.sv
sv/occ_dp.sv
sv/oled_controller_command_ram.sv
sv/occ_checker.sv
dv/tb_top.sv
